### hw/rtl/pngcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pngcs_pkg: shared types, constants and the CRC function
// Transaction types, chunk codes, scoring weights and the bytewise CRC-32.
// ----------------------------------------------------------------------------
package pngcs_pkg;

  // Input transaction: one byte of the candidate file.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // Result transaction: one per candidate, on its last byte.
  typedef struct packed {
    logic [6:0] score_pct;
    logic [1:0] verdict;
    logic       signature_ok;
    logic       saw_header_chunk;
    logic       saw_data_chunk;
    logic       saw_end_chunk;
    logic       checksum_failed;
  } out_t;

  // Classified byte, queued between the front and the back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       crc_init;    // first type byte: restart the CRC
    logic       crc_data;    // type or data byte: fold into the CRC
    logic       crc_stored;  // stored CRC byte: shift into the compare word
    logic       set_ihdr;
    logic       set_idat;
    logic       set_iend;
    logic       chunk_end;   // last stored CRC byte: compare now
    logic       sig_ok;      // meaningful on the last byte only
    logic       size_ok;     // meaningful on the last byte only
  } qent_t;

  // PNG signature.
  localparam logic [7:0] SIG_BYTES [8] = '{
    8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
  };

  // Chunk type codes.
  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

  // Size window for the size weight.
  localparam logic [31:0] SIZE_MIN_BYTES = 32'd45;
  localparam logic [31:0] SIZE_MAX_BYTES = 32'd104857600;

  // Scoring weights and penalties.
  localparam logic signed [7:0] W_SIGNATURE  = 8'sd20;
  localparam logic signed [7:0] W_END        = 8'sd20;
  localparam logic signed [7:0] P_NO_END     = 8'sd15;
  localparam logic signed [7:0] W_HDR_DATA   = 8'sd25;
  localparam logic signed [7:0] W_HDR_ONLY   = 8'sd15;
  localparam logic signed [7:0] W_CRC_CLEAN  = 8'sd5;
  localparam logic signed [7:0] P_CRC_BAD    = 8'sd15;
  localparam logic signed [7:0] W_SIZE       = 8'sd10;
  localparam logic signed [7:0] W_COMPLETE   = 8'sd20;
  localparam logic signed [7:0] SCORE_CAP    = 8'sd100;
  localparam logic signed [7:0] SCORE_VALID  = 8'sd80;
  localparam logic signed [7:0] SCORE_PARTIAL = 8'sd40;

  // Validation status codes.
  localparam logic [1:0] STATUS_VALID     = 2'd0;
  localparam logic [1:0] STATUS_PARTIAL   = 2'd1;
  localparam logic [1:0] STATUS_CORRUPTED = 2'd2;

  // Reflected CRC-32 polynomial.
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // Fold one byte into a reflected CRC-32, one bit per step.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/png_chunk_confidence_scorer_core.sv
`default_nettype none
// One byte transaction per cycle is accepted while the two-entry queue has room.
// A result turns valid once its last byte has passed the queue: the edge that
// accepts it writes a queue slot, and the output register loads when it pops.
// Throughput is one byte per cycle while no result is held; the bytewise CRC
// in the back end sets it. Synchronous reset clears the counters, the queue and
// the output valid; every candidate's last byte also resets all candidate state.
// ----------------------------------------------------------------------------
// png_chunk_confidence_scorer_core: PNG chunk confidence scorer
// Walks a carved PNG candidate byte by byte and scores it on its last byte.
// ----------------------------------------------------------------------------
module png_chunk_confidence_scorer_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            byte_valid,
  output logic                 byte_stall,
  input  wire pngcs_pkg::in_t  byte_item,
  output logic                 score_valid,
  input  wire logic            score_stall,
  output pngcs_pkg::out_t      score_item
);

  pngcs_pkg::qent_t entry;
  pngcs_pkg::qent_t q_head;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_valid;

  assign byte_stall = q_full;
  assign push       = byte_valid && !byte_stall;

  // Front end: positions and classification.
  pngcs_front u_front (
    .clk   (clk),
    .rst   (rst),
    .item  (byte_item),
    .push  (push),
    .entry (entry)
  );

  // Decoupling queue.
  pngcs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (entry),
    .pop      (pop),
    .full     (q_full),
    .nonempty (q_valid),
    .head     (q_head)
  );

  // Back end: CRC, flags and scoring.
  pngcs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head    (q_head),
    .pop     (pop),
    .valid   (score_valid),
    .stall   (score_stall),
    .result  (score_item)
  );

  // A held result must never be overwritten by the next candidate's last byte.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_head.last_byte && score_valid && score_stall) |-> !pop)
    else $error("last byte popped while a result is still held");

  // The clamped score stays within range.
  a_score_range: assert property (@(posedge clk) disable iff (rst)
    score_valid |-> (score_item.score_pct <= 7'd100))
    else $error("confidence score above 100");

  // Status agrees with the score thresholds.
  a_status_valid: assert property (@(posedge clk) disable iff (rst)
    (score_valid && score_item.verdict == pngcs_pkg::STATUS_VALID)
      |-> (score_item.score_pct >= 7'd80))
    else $error("valid status with a low score");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    score_valid |-> (score_item.verdict <= pngcs_pkg::STATUS_CORRUPTED))
    else $error("undefined validation status");

endmodule
`default_nettype wire

### hw/rtl/pngcs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pngcs_front: byte position tracking and classification
// Counts bytes, checks the signature and walks chunk boundaries, tagging each
// accepted byte with what the back end has to do with it.
// ----------------------------------------------------------------------------
module pngcs_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire pngcs_pkg::in_t  item,
  input  wire logic            push,
  output pngcs_pkg::qent_t     entry
);

  logic [31:0] cnt;
  logic        sig_match;
  logic [32:0] rel;        // byte offset inside the current chunk
  logic        stopped;
  logic [23:0] len;        // length bytes gathered so far
  logic [32:0] data_end;   // offset of the first stored CRC byte
  logic [32:0] crc_end;    // offset of the last stored CRC byte
  logic [31:0] chunk_type;

  logic        active;
  logic [31:0] cnt_next;
  logic        sig_bad;
  logic        walk;
  logic [31:0] len_full;
  logic        in_len;
  logic        in_type;
  logic        is_end;
  logic [7:0]  b;

  assign b = item.data_byte;

  // Position bookkeeping; the counter saturates and stops the walk there.
  always_comb begin
    active   = (cnt != '1);
    cnt_next = active ? (cnt + 32'd1) : cnt;
    sig_bad  = active && (cnt[31:3] == '0) && (b != pngcs_pkg::SIG_BYTES[cnt[2:0]]);
    walk     = active && !stopped && (cnt[31:3] != '0);
    len_full = (rel == 33'd0) ? {24'd0, b} : {len, b};
    in_len   = walk && (rel[32:2] == '0);
    in_type  = walk && !in_len && (rel[32:3] == '0);
    is_end   = walk && (rel[32:2] != '0) && (rel == crc_end);
  end

  // Classification of the byte for the back end.
  always_comb begin
    entry            = '0;
    entry.data_byte  = b;
    entry.last_byte  = item.last_byte;
    entry.crc_init   = in_type && (rel == 33'd4);
    entry.crc_data   = in_type || (walk && !in_len && !in_type && (rel < data_end));
    entry.crc_stored = walk && !in_len && !in_type && !(rel < data_end);
    entry.set_ihdr   = walk && (rel == 33'd11) && (chunk_type == pngcs_pkg::TYPE_IHDR);
    entry.set_idat   = walk && (rel == 33'd11) && (chunk_type == pngcs_pkg::TYPE_IDAT);
    entry.set_iend   = walk && (rel == 33'd11) && (chunk_type == pngcs_pkg::TYPE_IEND);
    entry.chunk_end  = is_end;
    entry.sig_ok     = sig_match && !sig_bad && (cnt_next[31:3] != '0);
    entry.size_ok    = (cnt_next >= pngcs_pkg::SIZE_MIN_BYTES) &&
                       (cnt_next <= pngcs_pkg::SIZE_MAX_BYTES);
  end

  // Control state; the last byte returns everything to its reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      sig_match <= 1'b1;
      rel       <= '0;
      stopped   <= 1'b0;
    end else if (push) begin
      if (item.last_byte) begin
        cnt       <= '0;
        sig_match <= 1'b1;
        rel       <= '0;
        stopped   <= 1'b0;
      end else begin
        cnt <= cnt_next;
        if (sig_bad) begin
          sig_match <= 1'b0;
        end
        if (walk) begin
          if (is_end) begin
            if (chunk_type == pngcs_pkg::TYPE_IEND) begin
              stopped <= 1'b1;
            end else begin
              rel <= '0;
            end
          end else begin
            rel <= rel + 33'd1;
          end
        end
      end
    end
  end

  // Chunk header fields.
  always_ff @(posedge clk) begin
    if (push && in_len) begin
      len <= len_full[23:0];
      if (rel == 33'd3) begin
        data_end <= {1'b0, len_full} + 33'd8;
        crc_end  <= {1'b0, len_full} + 33'd11;
      end
    end
    if (push && in_type) begin
      chunk_type <= {chunk_type[23:0], b};
    end
  end

endmodule
`default_nettype wire

### hw/rtl/pngcs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pngcs_queue: two-entry queue between front and back
// Lets the front keep taking bytes while the back waits on the result port.
// ----------------------------------------------------------------------------
module pngcs_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire pngcs_pkg::qent_t  wr_entry,
  input  wire logic              pop,
  output logic                   full,
  output logic                   nonempty,
  output pngcs_pkg::qent_t       head
);

  pngcs_pkg::qent_t slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign head     = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/pngcs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pngcs_back: CRC, chunk flags and scoring
// Runs the chunk CRC, records the chunks seen and scores the candidate on its
// last byte into an output register.
// ----------------------------------------------------------------------------
module pngcs_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire pngcs_pkg::qent_t  head,
  output logic                   pop,
  output logic                   valid,
  input  wire logic              stall,
  output pngcs_pkg::out_t        result
);

  logic [31:0] crc;
  logic [31:0] stored;
  logic        f_ihdr;
  logic        f_idat;
  logic        f_iend;
  logic        f_bad;

  logic [31:0]       crc_next;
  logic [31:0]       stored_next;
  logic              ihdr;
  logic              idat;
  logic              iend;
  logic              bad;
  logic signed [7:0] score;
  logic [6:0]        score_clamped;
  pngcs_pkg::out_t   result_next;

  // A non-last byte never waits; the last one waits for a free output slot.
  assign pop = q_valid && (!head.last_byte || !valid || !stall);

  // Per-byte updates of CRC, compare word and flags.
  always_comb begin
    crc_next    = crc;
    stored_next = stored;
    if (head.crc_data) begin
      crc_next = pngcs_pkg::crc_byte(head.crc_init ? 32'hFFFF_FFFF : crc, head.data_byte);
    end
    if (head.crc_stored) begin
      stored_next = {stored[23:0], head.data_byte};
    end
    ihdr = f_ihdr || head.set_ihdr;
    idat = f_idat || head.set_idat;
    iend = f_iend || head.set_iend;
    bad  = f_bad || (head.chunk_end && ((~crc) != stored_next));
  end

  // Score total, clamp and status.
  always_comb begin
    score = '0;
    if (head.sig_ok) score = score + pngcs_pkg::W_SIGNATURE;
    if (iend) score = score + pngcs_pkg::W_END;
    else      score = score - pngcs_pkg::P_NO_END;
    if (ihdr && idat) score = score + pngcs_pkg::W_HDR_DATA;
    else if (ihdr)    score = score + pngcs_pkg::W_HDR_ONLY;
    if (!bad && (ihdr || iend)) score = score + pngcs_pkg::W_CRC_CLEAN;
    else if (bad)               score = score - pngcs_pkg::P_CRC_BAD;
    if (head.size_ok) score = score + pngcs_pkg::W_SIZE;
    if (ihdr && iend && !bad) score = score + pngcs_pkg::W_COMPLETE;

    if (score < 8'sd0) begin
      score_clamped = '0;
    end else if (score > pngcs_pkg::SCORE_CAP) begin
      score_clamped = pngcs_pkg::SCORE_CAP[6:0];
    end else begin
      score_clamped = score[6:0];
    end

    result_next.score_pct = score_clamped;
    if (score >= pngcs_pkg::SCORE_VALID) begin
      result_next.verdict = pngcs_pkg::STATUS_VALID;
    end else if (score >= pngcs_pkg::SCORE_PARTIAL) begin
      result_next.verdict = pngcs_pkg::STATUS_PARTIAL;
    end else begin
      result_next.verdict = pngcs_pkg::STATUS_CORRUPTED;
    end
    result_next.signature_ok     = head.sig_ok;
    result_next.saw_header_chunk = ihdr;
    result_next.saw_data_chunk   = idat;
    result_next.saw_end_chunk    = iend;
    result_next.checksum_failed  = bad;
  end

  // Candidate state; the last byte returns it to reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc    <= 32'hFFFF_FFFF;
      stored <= '0;
      f_ihdr <= 1'b0;
      f_idat <= 1'b0;
      f_iend <= 1'b0;
      f_bad  <= 1'b0;
    end else if (pop) begin
      if (head.last_byte) begin
        crc    <= 32'hFFFF_FFFF;
        stored <= '0;
        f_ihdr <= 1'b0;
        f_idat <= 1'b0;
        f_iend <= 1'b0;
        f_bad  <= 1'b0;
      end else begin
        crc    <= crc_next;
        stored <= stored_next;
        f_ihdr <= ihdr;
        f_idat <= idat;
        f_iend <= iend;
        f_bad  <= bad;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pop && head.last_byte) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last_byte) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire
